FILE: design/moe_capacity_slot_assigner_top_assert.svh
// Assertion macros for the slot assigner. Each expects clk and rst_n in scope.
`ifndef MOE_CAPACITY_SLOT_ASSIGNER_TOP_ASSERT_SVH
`define MOE_CAPACITY_SLOT_ASSIGNER_TOP_ASSERT_SVH

// Same-cycle implication.
`define MCSA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slot assigner check failed");

// Next-cycle implication.
`define MCSA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slot assigner check failed");

`endif

FILE: design/moe_csa_pkg.sv
`timescale 1ns / 1ps

package moe_csa_pkg;

    localparam int DEF_MAX_EXPERTS  = 64;
    localparam int DEF_MAX_CAPACITY = 1024;

    localparam int NUM_EXPERTS_W = 7;
    localparam int CAPACITY_W    = 11;
    localparam int CFG_DATA_W    = 11;
    localparam int CFG_IDX_W     = 1;
    localparam int SLOT_W        = 17;

    localparam logic [NUM_EXPERTS_W-1:0] RST_NUM_EXPERTS = 7'd64;
    localparam logic [CAPACITY_W-1:0]    RST_CAPACITY    = 11'd16;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_EXPERTS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY    = 1'b1;

    localparam logic [1:0] ST_PLACED  = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic               start_batch;
        logic signed [15:0] expert_id;
        logic [11:0]        token_index;
        logic [2:0]         choice_index;
    } in_beat_t;

    typedef struct packed {
        logic signed [SLOT_W-1:0] slot_index;
        logic [1:0]               status;
        logic [11:0]              token_out;
        logic [2:0]               choice_out;
    } out_beat_t;

endpackage

FILE: design/moe_capacity_slot_assigner_top.sv
`timescale 1ns / 1ps
// Channel  | Handshake                | Payload
// ---------+--------------------------+---------------------------------
// input    | in_valid / in_stall      | in_data  (in_beat_t)
// output   | out_valid / out_stall    | out_data (out_beat_t)
// config   | cfg_we                   | cfg_index, cfg_data
//
// One beat per cycle sustained while the output is not stalled; the counter memory is
// read at the input accept edge, then check/update/slot multiply feed the output reg.
// Back-to-back beats to the same expert use a forwarded copy of the last write.
// Reset clears all fill counters at once via per-expert valid bits and loads
// the register defaults (64 experts, capacity 16).
// A stalled output holds the pipeline; input stalls only when both stages are full
// and the output is stalled.

`include "moe_capacity_slot_assigner_top_assert.svh"

module moe_capacity_slot_assigner_top
    import moe_csa_pkg::*;
#(
    parameter int MAX_EXPERTS  = DEF_MAX_EXPERTS,
    parameter int MAX_CAPACITY = DEF_MAX_CAPACITY
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_beat_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_beat_t             out_data
);

    localparam int EXP_W  = (MAX_EXPERTS > 1) ? $clog2(MAX_EXPERTS) : 1;
    localparam int CNT_W  = (MAX_CAPACITY >= 2047) ? CAPACITY_W : $clog2(MAX_CAPACITY + 1);
    localparam int PROD_W = EXP_W + CAPACITY_W;

    logic [NUM_EXPERTS_W-1:0] num_experts_reg;
    logic [CAPACITY_W-1:0]    capacity_reg;

    logic [NUM_EXPERTS_W-1:0] ne_eff;
    logic [CAPACITY_W-1:0]    cap_eff;

    logic                     s1_valid_reg;
    in_beat_t                 s1_data_reg;
    logic [CNT_W-1:0]         rd_cnt_reg;
    logic [MAX_EXPERTS-1:0]   vld_reg;
    logic [EXP_W-1:0]         fwd_idx_reg;
    logic [CNT_W-1:0]         fwd_cnt_reg;
    logic                     out_valid_reg;
    out_beat_t                out_data_reg;
    out_beat_t                out_next;

    logic [CNT_W-1:0]         cnt_mem [MAX_EXPERTS];

    logic                     in_fire;
    logic                     s1_adv;
    logic                     s1_fire;
    logic [EXP_W-1:0]         in_idx;
    logic [EXP_W-1:0]         s1_idx;
    logic                     id_ok;
    logic [CNT_W-1:0]         cnt_cur;
    logic                     has_room;
    logic                     cnt_wr;
    logic [PROD_W-1:0]        slot_sum;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_experts_reg <= RST_NUM_EXPERTS;
            capacity_reg    <= RST_CAPACITY;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NUM_EXPERTS: num_experts_reg <= cfg_data[NUM_EXPERTS_W-1:0];
                REG_CAPACITY:    capacity_reg    <= cfg_data[CAPACITY_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        ne_eff  = (32'(num_experts_reg) > MAX_EXPERTS) ? NUM_EXPERTS_W'(MAX_EXPERTS)
                                                       : num_experts_reg;
        cap_eff = (32'(capacity_reg) > MAX_CAPACITY) ? CAPACITY_W'(MAX_CAPACITY)
                                                     : capacity_reg;
    end

    // Handshake
    assign s1_adv   = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && s1_adv;
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_fire  = in_valid && !in_stall;
    assign in_idx   = in_data.expert_id[EXP_W-1:0];

    // Stage 1: input register and counter read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_adv || !s1_valid_reg)
        begin
            s1_valid_reg <= in_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_data_reg <= in_data;
            rd_cnt_reg  <= cnt_mem[in_idx];
        end
    end

    // Check, update and slot
    always_comb
    begin
        s1_idx = s1_data_reg.expert_id[EXP_W-1:0];
        id_ok  = $unsigned(s1_data_reg.expert_id) < {{(16-NUM_EXPERTS_W){1'b0}}, ne_eff};

        // start clears, invalid entries read zero, last write bypasses the memory
        if (s1_data_reg.start_batch || !vld_reg[s1_idx])
        begin
            cnt_cur = '0;
        end
        else if (fwd_idx_reg == s1_idx)
        begin
            cnt_cur = fwd_cnt_reg;
        end
        else
        begin
            cnt_cur = rd_cnt_reg;
        end

        has_room = CAPACITY_W'(cnt_cur) < cap_eff;
        cnt_wr   = s1_fire && id_ok && has_room;
        slot_sum = PROD_W'(s1_idx) * PROD_W'(cap_eff) + PROD_W'(cnt_cur);

        out_next.token_out  = s1_data_reg.token_index;
        out_next.choice_out = s1_data_reg.choice_index;
        if (!id_ok)
        begin
            out_next.status     = ST_INVALID;
            out_next.slot_index = '1;
        end
        else if (has_room)
        begin
            out_next.status     = ST_PLACED;
            out_next.slot_index = $signed(SLOT_W'(slot_sum));
        end
        else
        begin
            out_next.status     = ST_FULL;
            out_next.slot_index = '1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cnt_wr)
        begin
            cnt_mem[s1_idx] <= cnt_cur + CNT_W'(1);
            fwd_idx_reg     <= s1_idx;
            fwd_cnt_reg     <= cnt_cur + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (s1_fire)
        begin
            if (s1_data_reg.start_batch)
            begin
                vld_reg <= '0;
            end
            if (cnt_wr)
            begin
                vld_reg[s1_idx] <= 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_data_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `MCSA_ASSERT_NOW(a_unplaced_slot, out_valid_reg && out_data_reg.status != ST_PLACED, out_data_reg.slot_index == '1)
    `MCSA_ASSERT_NOW(a_stall_full, in_stall, s1_valid_reg && out_valid_reg && out_stall)
    `MCSA_ASSERT_NEXT(a_beat_moves, s1_valid_reg && s1_adv, out_valid_reg)

endmodule
